/* hw/rtl/ogtmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogtmp_pkg
// Shared types and constants of the occupancy grid tile max pool.
// ----------------------------------------------------------------------------
package ogtmp_pkg;

	localparam int MAX_FINE_SIZE = 4096;
	localparam int MAX_TILE      = 63;

	localparam int POS_W   = $clog2(MAX_FINE_SIZE);
	localparam int SIZE_W  = POS_W + 1;
	localparam int TILE_W  = $clog2(MAX_TILE + 1);
	localparam int CELL_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CELL_W-1:0] CELL_FREE     = 2'd0;
	localparam logic [CELL_W-1:0] CELL_HALLWAY  = 2'd1;
	localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;
	localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FINE_OUTER_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINE_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SPACING    = 2'd2;

	localparam logic [SIZE_W-1:0] RST_FINE_OUTER_SIZE = SIZE_W'(256);
	localparam logic [SIZE_W-1:0] RST_FINE_INNER_SIZE = SIZE_W'(256);
	localparam logic [TILE_W-1:0] RST_TILE_SPACING    = TILE_W'(5);

	typedef struct packed {
		logic [POS_W-1:0]  coarse_inner;
		logic [POS_W-1:0]  coarse_outer;
		logic [CELL_W-1:0] coarse_state;
	} coarse_data_t;

	typedef struct packed {
		logic         grid_last;
		coarse_data_t data;
	} result_t;

	localparam int RESULT_DATA_W = $bits(coarse_data_t);

endpackage

/* hw/rtl/ogtmp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogtmp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ogtmp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/occupancy_grid_tile_max_pool.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_tile_max_pool
// Downsamples a streamed fine occupancy grid into a coarse grid by taking the
// priority maximum (occupied > hallway > free) over N-by-N tiles.
//
// Usage:
//   s_* carries fine cells, outer index slow, inner index fast; one request
//   per cell. m_* carries coarse cells; m_tlast marks the final coarse cell
//   of the grid. cfg_* writes sizes and spacing (index 0 outer size,
//   1 inner size, 2 spacing); cfg_ready is always high and a valid write
//   to index 0, 1 or 2 restarts the grid at the origin. Write only while
//   the stream is idle. Throughput is one fine cell per cycle while s_tready
//   is high, set by the read-modify-write of the accumulator RAM (read issued
//   at accept, write in the next cycle, with forwarding of the previous write).
//   m_tvalid rises once a tile's last fine cell has passed stage 1 into the queue.
//   A three-entry output queue decouples the receiver; when it stalls the
//   queue fills and s_tready drops until room returns. No request is lost.
//   Reset sets sizes 256 x 256, spacing 5, and the origin position. The
//   accumulator RAM is not swept: each entry is cleared on the first cell of
//   its tile, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module occupancy_grid_tile_max_pool (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ogtmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ogtmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// fine cells
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ogtmp_pkg::IN_TDATA_W-1:0]    s_tdata,   // [1:0] cell_state
	// coarse cells
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ogtmp_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [1:0] coarse_state,
	                                                       // [13:2] coarse_outer,
	                                                       // [25:14] coarse_inner
	output logic                                m_tlast    // grid_last
);

	import ogtmp_pkg::*;

	localparam int QDEPTH = 3;
	localparam int QPTR_W = 2;
	localparam int CALC_W = SIZE_W + 1;

	// configuration registers
	logic [SIZE_W-1:0] outer_size_q;
	logic [SIZE_W-1:0] inner_size_q;
	logic [TILE_W-1:0] spacing_q;

	// grid position
	logic [POS_W-1:0]  outer_pos_q;
	logic [POS_W-1:0]  inner_pos_q;
	logic [TILE_W-1:0] outer_off_q;
	logic [TILE_W-1:0] inner_off_q;
	logic [POS_W-1:0]  outer_idx_q;
	logic [POS_W-1:0]  inner_idx_q;

	// stage 1
	logic              valid_s1;
	logic [CELL_W-1:0] cell_s1;
	logic [POS_W-1:0]  slot_s1;
	logic              clear_s1;
	logic              emit_s1;
	logic [POS_W-1:0]  outer_s1;
	logic              last_s1;

	// forwarding of the last RAM write
	logic              fwd_valid_q;
	logic [POS_W-1:0]  fwd_slot_q;
	logic [CELL_W-1:0] fwd_val_q;

	// output queue
	result_t           queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] count_q;

	// derived configuration
	logic [SIZE_W-1:0] w_sz;
	logic [SIZE_W-1:0] h_sz;
	logic [TILE_W-1:0] n_raw;
	logic [TILE_W-1:0] n_sz;
	logic [TILE_W-1:0] step;
	logic              grid_on;

	// stage 0
	logic              restart;
	logic [POS_W-1:0]  op, ip, oi, ii;
	logic [TILE_W-1:0] oo, io;
	logic [CALC_W-1:0] outer_start, inner_start;
	logic              in_outer, in_inner, last_outer, last_inner;
	logic              in_tile, clear_c, emit_c;
	logic [SIZE_W-1:0] op_n, ip_n, oi_n, ii_n;
	logic [TILE_W:0]   oo_n, io_n;
	logic              cfg_hit;
	logic              accept;
	logic              take;
	logic [CELL_W-1:0] cell_in;

	// stage 1 logic
	logic [CELL_W-1:0] acc_base;
	logic [CELL_W-1:0] acc_new;
	logic [CELL_W-1:0] ram_rd_data;
	logic              push;
	logic              pop;

	assign cfg_ready = 1'b1;
	assign cell_in   = s_tdata[CELL_W-1:0];

	always_comb begin
		w_sz  = (outer_size_q > SIZE_W'(MAX_FINE_SIZE)) ? SIZE_W'(MAX_FINE_SIZE) : outer_size_q;
		h_sz  = (inner_size_q > SIZE_W'(MAX_FINE_SIZE)) ? SIZE_W'(MAX_FINE_SIZE) : inner_size_q;
		n_raw = (spacing_q > TILE_W'(MAX_TILE)) ? TILE_W'(MAX_TILE) : spacing_q;
		if (n_raw == '0) begin
			n_sz = '0;
		end else if (n_raw[0]) begin
			n_sz = n_raw;
		end else begin
			n_sz = n_raw - TILE_W'(1);
		end
		step    = n_sz >> 1;
		grid_on = (n_sz != '0) && (w_sz > SIZE_W'(step)) && (h_sz > SIZE_W'(step));
	end

	always_comb begin
		restart = (SIZE_W'(outer_pos_q) >= w_sz) || (SIZE_W'(inner_pos_q) >= h_sz) ||
		          (outer_off_q >= n_sz) || (inner_off_q >= n_sz);
		op = restart ? '0 : outer_pos_q;
		ip = restart ? '0 : inner_pos_q;
		oo = restart ? '0 : outer_off_q;
		io = restart ? '0 : inner_off_q;
		oi = restart ? '0 : outer_idx_q;
		ii = restart ? '0 : inner_idx_q;

		// tile centre = tile start + step; a tile exists while its centre fits
		outer_start = CALC_W'(op) - CALC_W'(oo);
		inner_start = CALC_W'(ip) - CALC_W'(io);
		in_outer    = (outer_start + CALC_W'(step)) < CALC_W'(w_sz);
		in_inner    = (inner_start + CALC_W'(step)) < CALC_W'(h_sz);
		last_outer  = (outer_start + CALC_W'(n_sz) + CALC_W'(step)) >= CALC_W'(w_sz);
		last_inner  = (inner_start + CALC_W'(n_sz) + CALC_W'(step)) >= CALC_W'(h_sz);
		in_tile     = in_outer && in_inner;
		clear_c     = (oo == '0) && (io == '0);
		emit_c      = ((oo == n_sz - TILE_W'(1)) || (SIZE_W'(op) == w_sz - SIZE_W'(1))) &&
		              ((io == n_sz - TILE_W'(1)) || (SIZE_W'(ip) == h_sz - SIZE_W'(1)));

		// advance
		ip_n = SIZE_W'(ip) + SIZE_W'(1);
		io_n = (TILE_W+1)'(io) + (TILE_W+1)'(1);
		ii_n = SIZE_W'(ii);
		op_n = SIZE_W'(op);
		oo_n = (TILE_W+1)'(oo);
		oi_n = SIZE_W'(oi);
		if (io_n == (TILE_W+1)'(n_sz)) begin
			io_n = '0;
			ii_n = ii_n + SIZE_W'(1);
		end
		if (ip_n >= h_sz) begin
			ip_n = '0;
			io_n = '0;
			ii_n = '0;
			op_n = op_n + SIZE_W'(1);
			oo_n = oo_n + (TILE_W+1)'(1);
			if (oo_n == (TILE_W+1)'(n_sz)) begin
				oo_n = '0;
				oi_n = oi_n + SIZE_W'(1);
			end
			if (op_n >= w_sz) begin
				op_n = '0;
				oo_n = '0;
				oi_n = '0;
			end
		end
	end

	assign s_tready = ({1'b0, count_q} + {2'b0, valid_s1 & emit_s1}) <= 3'd2;
	assign accept   = s_tvalid && s_tready;
	assign take     = accept && grid_on;
	assign cfg_hit  = cfg_valid && (cfg_index == REG_FINE_OUTER_SIZE ||
	                  cfg_index == REG_FINE_INNER_SIZE || cfg_index == REG_TILE_SPACING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_size_q <= RST_FINE_OUTER_SIZE;
			inner_size_q <= RST_FINE_INNER_SIZE;
			spacing_q    <= RST_TILE_SPACING;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FINE_OUTER_SIZE: outer_size_q <= cfg_data;
				REG_FINE_INNER_SIZE: inner_size_q <= cfg_data;
				REG_TILE_SPACING:    spacing_q    <= cfg_data[TILE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_pos_q <= '0;
			inner_pos_q <= '0;
			outer_off_q <= '0;
			inner_off_q <= '0;
			outer_idx_q <= '0;
			inner_idx_q <= '0;
		end else if (cfg_hit) begin
			outer_pos_q <= '0;
			inner_pos_q <= '0;
			outer_off_q <= '0;
			inner_off_q <= '0;
			outer_idx_q <= '0;
			inner_idx_q <= '0;
		end else if (take) begin
			outer_pos_q <= op_n[POS_W-1:0];
			inner_pos_q <= ip_n[POS_W-1:0];
			outer_off_q <= oo_n[TILE_W-1:0];
			inner_off_q <= io_n[TILE_W-1:0];
			outer_idx_q <= oi_n[POS_W-1:0];
			inner_idx_q <= ii_n[POS_W-1:0];
		end
	end

	// stage 1 pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take && in_tile;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1  <= cell_in;
			slot_s1  <= ii;
			clear_s1 <= clear_c;
			emit_s1  <= emit_c;
			outer_s1 <= oi;
			last_s1  <= last_outer && last_inner;
		end
	end

	ogtmp_ram #(
		.WIDTH(CELL_W),
		.DEPTH(MAX_FINE_SIZE)
	) u_acc_ram (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (slot_s1),
		.wr_data (acc_new),
		.rd_en   (accept),
		.rd_addr (ii),
		.rd_data (ram_rd_data)
	);

	always_comb begin
		if (clear_s1) begin
			acc_base = CELL_FREE;
		end else if (fwd_valid_q && fwd_slot_q == slot_s1) begin
			acc_base = fwd_val_q;
		end else begin
			acc_base = ram_rd_data;
		end
		case (cell_s1)
			CELL_OCCUPIED: acc_new = CELL_OCCUPIED;
			CELL_HALLWAY:  acc_new = (acc_base == CELL_FREE) ? CELL_HALLWAY : acc_base;
			default:       acc_new = acc_base;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fwd_slot_q <= slot_s1;
			fwd_val_q  <= acc_new;
		end
	end

	// output queue
	assign push = valid_s1 && emit_s1;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QPTR_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QPTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q].grid_last         <= last_s1;
			queue_q[wr_ptr_q].data.coarse_inner <= slot_s1;
			queue_q[wr_ptr_q].data.coarse_outer <= outer_s1;
			queue_q[wr_ptr_q].data.coarse_state <= acc_new;
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {{(OUT_TDATA_W - RESULT_DATA_W){1'b0}}, queue_q[rd_ptr_q].data};
	assign m_tlast  = queue_q[rd_ptr_q].grid_last;

endmodule

/* test/tile_pool_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_pool_checker
// Watches the configuration, fine cell and coarse cell channels of the tile
// max pool. It keeps its own copy of the registers, positions and band
// accumulators, predicts each coarse cell and compares it field by field.
// ----------------------------------------------------------------------------
module tile_pool_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [ogtmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ogtmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [ogtmp_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [ogtmp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                                m_tlast,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  checked
);
	import ogtmp_pkg::*;

	logic [SIZE_W-1:0] outer_size;
	logic [SIZE_W-1:0] inner_size;
	logic [TILE_W-1:0] spacing;
	logic [CELL_W-1:0] band_acc [MAX_FINE_SIZE];
	logic [SIZE_W-1:0] pos_outer;
	logic [SIZE_W-1:0] pos_inner;
	logic [TILE_W-1:0] off_outer;
	logic [TILE_W-1:0] off_inner;
	logic [SIZE_W-1:0] tile_outer;
	logic [SIZE_W-1:0] tile_inner;
	result_t           coarse_expected [$];

	// number of tile centres half + k*n below size
	function automatic int centres_below(input int size, input int n, input int half);
		if (size <= half)
			return 0;
		return (size - 1 - half) / n + 1;
	endfunction

	task automatic restart_grid();
		pos_outer  = '0;
		pos_inner  = '0;
		off_outer  = '0;
		off_inner  = '0;
		tile_outer = '0;
		tile_inner = '0;
	endtask

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("tile_pool_checker: %s", msg);
	endtask

	always @(posedge clk) begin : watch
		int                w;
		int                h;
		int                n;
		int                half;
		int                n_out;
		int                n_in;
		logic [CELL_W-1:0] fine_code;
		logic [CELL_W-1:0] acc;
		result_t           exp_r;
		result_t           got_r;
		if (!arst_n) begin
			outer_size = RST_FINE_OUTER_SIZE;
			inner_size = RST_FINE_INNER_SIZE;
			spacing    = RST_TILE_SPACING;
			for (int i = 0; i < MAX_FINE_SIZE; i++)
				band_acc[i] = CELL_FREE;
			restart_grid();
			coarse_expected.delete();
			fail_count = 0;
			checked    = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.grid_last = m_tlast;
				got_r.data      = m_tdata[RESULT_DATA_W-1:0];
				if (coarse_expected.size() == 0) begin
					report_mismatch($sformatf("coarse cell %h with none expected", m_tdata));
				end else begin
					exp_r = coarse_expected.pop_front();
					checked++;
					if (got_r.data.coarse_state !== exp_r.data.coarse_state ||
					    got_r.data.coarse_outer !== exp_r.data.coarse_outer ||
					    got_r.data.coarse_inner !== exp_r.data.coarse_inner ||
					    got_r.grid_last !== exp_r.grid_last ||
					    m_tdata[OUT_TDATA_W-1:RESULT_DATA_W] !== '0)
						report_mismatch($sformatf(
							"got %0d (%0d,%0d) last %b pad %h, exp %0d (%0d,%0d) last %b",
							got_r.data.coarse_state, got_r.data.coarse_outer,
							got_r.data.coarse_inner, got_r.grid_last,
							m_tdata[OUT_TDATA_W-1:RESULT_DATA_W],
							exp_r.data.coarse_state, exp_r.data.coarse_outer,
							exp_r.data.coarse_inner, exp_r.grid_last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FINE_OUTER_SIZE: begin
						outer_size = cfg_data;
						restart_grid();
					end
					REG_FINE_INNER_SIZE: begin
						inner_size = cfg_data;
						restart_grid();
					end
					REG_TILE_SPACING: begin
						spacing = cfg_data[TILE_W-1:0];
						restart_grid();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				w = (outer_size > MAX_FINE_SIZE) ? MAX_FINE_SIZE : int'(outer_size);
				h = (inner_size > MAX_FINE_SIZE) ? MAX_FINE_SIZE : int'(inner_size);
				n = (spacing > MAX_TILE) ? MAX_TILE : int'(spacing);
				if (n > 0 && n % 2 == 0)
					n = n - 1;
				half  = n / 2;
				n_out = (n == 0) ? 0 : centres_below(w, n, half);
				n_in  = (n == 0) ? 0 : centres_below(h, n, half);
				if (n_out > 0 && n_in > 0) begin
					if (pos_outer >= w || pos_inner >= h || off_outer >= n || off_inner >= n)
						restart_grid();
					fine_code = s_tdata[CELL_W-1:0];
					if (tile_outer < n_out && tile_inner < n_in) begin
						acc = band_acc[tile_inner[POS_W-1:0]];
						if (off_outer == 0 && off_inner == 0)
							acc = CELL_FREE;
						if (fine_code == CELL_OCCUPIED)
							acc = CELL_OCCUPIED;
						else if (fine_code == CELL_HALLWAY && acc == CELL_FREE)
							acc = CELL_HALLWAY;
						band_acc[tile_inner[POS_W-1:0]] = acc;
						if ((off_outer == n - 1 || pos_outer == w - 1) &&
						    (off_inner == n - 1 || pos_inner == h - 1)) begin
							exp_r.data.coarse_state = acc;
							exp_r.data.coarse_outer = tile_outer[POS_W-1:0];
							exp_r.data.coarse_inner = tile_inner[POS_W-1:0];
							exp_r.grid_last = (tile_outer == n_out - 1 && tile_inner == n_in - 1);
							coarse_expected.insert(coarse_expected.size(), exp_r);
						end
					end
					pos_inner++;
					off_inner++;
					if (off_inner == n) begin
						off_inner = '0;
						tile_inner++;
					end
					if (pos_inner >= h) begin
						pos_inner  = '0;
						off_inner  = '0;
						tile_inner = '0;
						pos_outer++;
						off_outer++;
						if (off_outer == n) begin
							off_outer = '0;
							tile_outer++;
						end
						if (pos_outer >= w)
							restart_grid();
					end
				end
			end
			pending = coarse_expected.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the tile max pool with directed and random fine grids over many
// geometries and spacings, with random gaps on both streams and one long
// receiver hold-off; the checker predicts and compares every coarse cell.
// ----------------------------------------------------------------------------
module tb_top;
	import ogtmp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int HOLD_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	int fail_count;
	int pending;
	int checked;
	int send_idle_pct = 15;
	int recv_idle_pct = 55;
	bit hold_req = 1'b0;
	int cycles = 0;
	int fine_sent = 0;
	int grids = 0;

	always #2 clk = ~clk;

	occupancy_grid_tile_max_pool uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	tile_pool_checker pool_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** occupancy_grid_tile_max_pool: FAILED **");
			$finish;
		end
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				m_tready <= 1'b0;
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [CELL_W-1:0] pick_cell(input int bias);
		int r;
		r = $urandom_range(99);
		case (bias)
			0: return CELL_W'($urandom_range(3));
			1: return (r < 85) ? CELL_FREE : (r < 93) ? CELL_UNKNOWN : CELL_HALLWAY;
			2: return (r < 50) ? CELL_FREE : (r < 80) ? CELL_HALLWAY : CELL_UNKNOWN;
			default: return (r < 3) ? CELL_OCCUPIED : (r < 60) ? CELL_FREE :
			                (r < 80) ? CELL_HALLWAY : CELL_UNKNOWN;
		endcase
	endfunction

	task automatic send_cell(input logic [CELL_W-1:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(code);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		fine_sent++;
	endtask

	// wait until every coarse cell is out, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_grid(input int outer_n, input int inner_n, input int spacing_n);
		logic [CFG_DATA_W-1:0] spacing_word;
		int first;
		spacing_word = CFG_DATA_W'($urandom);
		spacing_word[TILE_W-1:0] = TILE_W'(spacing_n);
		first = $urandom_range(2);
		drain();
		for (int k = 0; k < 3; k++) begin
			case ((first + k) % 3)
				0: write_reg(REG_FINE_OUTER_SIZE, CFG_DATA_W'(outer_n));
				1: write_reg(REG_FINE_INNER_SIZE, CFG_DATA_W'(inner_n));
				default: write_reg(REG_TILE_SPACING, spacing_word);
			endcase
		end
		grids++;
	endtask

	initial begin : stimulus
		int outer_n;
		int inner_n;
		int spacing_n;
		int eff;
		int cells;
		int count;
		int bias;
		int pick;
		int rand_items;
		bit ignored;
		bit pressed;
		rand_items = 0;
		pressed = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry, no tile completes yet
		send_cell(CELL_OCCUPIED); send_cell(CELL_HALLWAY);
		drain();
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		// even spacing two lowers to one: each fine cell is its own tile
		set_grid(2, 3, 2);
		send_cell(CELL_FREE); send_cell(CELL_HALLWAY); send_cell(CELL_OCCUPIED);
		send_cell(CELL_UNKNOWN); send_cell(CELL_OCCUPIED); send_cell(CELL_HALLWAY);
		// single 3x3 tile: hallway wins over free, unknown has no effect
		set_grid(3, 3, 3);
		send_cell(CELL_HALLWAY); send_cell(CELL_UNKNOWN); send_cell(CELL_FREE);
		send_cell(CELL_FREE); send_cell(CELL_HALLWAY); send_cell(CELL_UNKNOWN);
		send_cell(CELL_FREE); send_cell(CELL_FREE); send_cell(CELL_FREE);
		// zero spacing
		set_grid(3, 3, 0);
		send_cell(CELL_FREE); send_cell(CELL_OCCUPIED); send_cell(CELL_HALLWAY);
		// empty inner axis
		set_grid(3, 0, 3);
		send_cell(CELL_OCCUPIED); send_cell(CELL_UNKNOWN);
		// oversized sizes saturate, widest spacing
		set_grid(8191, 8191, 63);
		send_cell(CELL_OCCUPIED); send_cell(CELL_HALLWAY); send_cell(CELL_FREE);

		// one full grid at the widest spacing, mostly free cells
		set_grid(32, 32, 63);
		repeat (1024) send_cell(pick_cell(1));
		rand_items += 1024;

		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 15;
				recv_idle_pct = 55;
			end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 55;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			ignored = 1'b0;
			bias = $urandom_range(3);
			if (!pressed && rand_items >= RANDOM_ITEMS / 2) begin
				// receiver holds off while every cell completes a tile
				set_grid(8, 8, 1);
				hold_req = 1'b1;
				repeat (64) send_cell(pick_cell(0));
				rand_items += 64;
				pressed = 1'b1;
				continue;
			end
			pick = $urandom_range(99);
			if (pick < 65) begin
				outer_n = $urandom_range(1, 14);
				inner_n = $urandom_range(1, 14);
				spacing_n = $urandom_range(1, 7);
				cells = outer_n * inner_n;
				count = cells * $urandom_range(1, 2) + $urandom_range(0, cells);
				if (count > 400)
					count = 400;
			end else if (pick < 75) begin
				// geometries that never produce a coarse cell
				case ($urandom_range(2))
					0: begin
						outer_n = $urandom_range(1, 20);
						inner_n = $urandom_range(1, 20);
						spacing_n = 0;
					end
					1: begin
						outer_n = $urandom_range(1) ? 0 : $urandom_range(1, 20);
						inner_n = (outer_n == 0) ? $urandom_range(0, 20) : 0;
						spacing_n = $urandom_range(1, 9);
					end
					default: begin
						spacing_n = $urandom_range(9, 63);
						outer_n = $urandom_range(1, 4);
						inner_n = $urandom_range(1, 40);
					end
				endcase
				count = $urandom_range(4, 12);
				ignored = 1'b1;
			end else if (pick < 88) begin
				spacing_n = $urandom_range(8, 21);
				eff = (spacing_n % 2 == 0) ? spacing_n - 1 : spacing_n;
				outer_n = $urandom_range(eff / 2 + 1, eff + 4);
				inner_n = $urandom_range(eff / 2 + 1, eff + 4);
				count = outer_n * inner_n + $urandom_range(0, 20);
			end else begin
				// one long axis, one tile per fine cell
				spacing_n = $urandom_range(1, 2);
				if ($urandom_range(1)) begin
					outer_n = $urandom_range(1, 2);
					inner_n = $urandom_range(1) ? 8191 : 4096;
				end else begin
					outer_n = $urandom_range(1) ? 8191 : 4096;
					inner_n = $urandom_range(1, 2);
				end
				count = $urandom_range(120, 250);
			end
			set_grid(outer_n, inner_n, spacing_n);
			repeat (count) send_cell(pick_cell(bias));
			if (!ignored) begin
				rand_items += count;
				// a write to the spare index must not restart the grid
				if ($urandom_range(7) == 0) begin
					drain();
					write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
					repeat (count / 2 + 1) send_cell(pick_cell(bias));
					rand_items += count / 2 + 1;
				end
			end
		end

		drain();
		repeat (20) @(negedge clk);
		$display("tile max pool: %0d fine cells over %0d geometries, %0d coarse cells checked",
		         fine_sent, grids, checked);
		$display("tile max pool: spacings 0 to 63, sizes 0 to 8191, one %0d-cycle output hold-off",
		         HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("** occupancy_grid_tile_max_pool: PASSED **");
		end else begin
			$display("** occupancy_grid_tile_max_pool: FAILED **");
		end
		$finish;
	end

endmodule
